// ----- sv/dpe_pkg.sv -----
// ----------------------------------------------------------------------------
// dpe_pkg: shared constants, types and helpers for the dipole potential block
// Fixed-point widths, register codes, the tag that travels with each request
// through the long arithmetic units, and bit-length helpers.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int NORM_BITS       = 20;
  localparam int CONST_EXP       = 15;
  localparam logic [31:0] CONST_MANT = 32'd2607594588;

  // normalized offset, squared radius, root and dot magnitude widths
  localparam int N_W   = NORM_BITS;
  localparam int R2_W  = 2 * NORM_BITS + 2;
  localparam int RT_W  = R2_W / 2;
  localparam int DM_W  = 38;
  localparam int SH_W  = 6;
  localparam int EXP_W = 10;

  localparam int SQRT_STEPS = RT_W;
  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = DIV_W;

  // exponent bias of the final scaling shift
  localparam int X_BIAS = 2 * COORD_FRAC_BITS - 22 - 66 - CONST_EXP;

  localparam int OUT_W = 48;
  localparam logic [OUT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_INTEN = 3'd6,
    REG_COND  = 3'd7
  } dpe_reg_t;

  // side data carried alongside each request
  typedef struct packed {
    logic                    at_src;
    logic                    neg;
    logic                    zero;
    logic signed [SH_W-1:0]  s;
    logic signed [EXP_W-1:0] ex;
    logic [RT_W-1:0]         rt;
    logic [R2_W-1:0]         r2;
    logic [DM_W-1:0]         dm;
  } dpe_tag_t;

  function automatic logic [6:0] bit_len64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [5:0] bit_len32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

// ----- sv/dpe_if.sv -----
// ----------------------------------------------------------------------------
// dpe_if: request channels of the dipole potential block
// Point channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpe_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface dpe_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] potential;
  logic               at_source;
  logic               saturated;

  modport source (output valid, output potential, output at_source,
                  output saturated, input ready);
  modport sink (input valid, input potential, input at_source,
                input saturated, output ready);
endinterface

// ----- sv/dpe_front.sv -----
// ----------------------------------------------------------------------------
// dpe_front: offset, normalization, squared radius and dot product
// Seven register stages from the measurement point to the tag that feeds
// the square root.
// ----------------------------------------------------------------------------
module dpe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic               out_valid,
  output dpe_pkg::dpe_tag_t  out_tag
);
  import dpe_pkg::*;

  logic [7:1] v;

  logic signed [31:0] pt  [3];
  logic signed [31:0] org [3];
  logic signed [15:0] dir [3];

  logic [31:0] mag1 [3];
  logic [2:0]  neg1;
  logic [31:0] mag2 [3];
  logic [2:0]  neg2;
  logic [31:0] m2;
  logic [31:0] mag3 [3];
  logic [2:0]  neg3;
  logic signed [SH_W-1:0] s3, s4, s5, s6;
  logic at3, at4, at5, at6;
  logic signed [N_W:0] sn4 [3];
  logic [N_W-1:0]      n4  [3];
  logic [2*N_W-1:0]    sq5 [3];
  logic signed [36:0]  pr5 [3];
  logic [R2_W-1:0]     r26;
  logic signed [38:0]  dot6;

  logic [31:0] m_next;
  logic [5:0]  len_next;
  logic signed [6:0] s_wide;
  logic signed [38:0] adot;
  dpe_tag_t tag_next;

  assign pt[0] = px;     assign pt[1] = py;     assign pt[2] = pz;
  assign org[0] = pos_x; assign org[1] = pos_y; assign org[2] = pos_z;
  assign dir[0] = dir_x; assign dir[1] = dir_y; assign dir[2] = dir_z;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], in_valid};
    end
  end

  // stage 1: signed offset split into sign and magnitude
  for (genvar i = 0; i < 3; i++) begin : g_off
    logic signed [32:0] d;
    logic signed [32:0] ad;
    assign d  = 33'(pt[i]) - 33'(org[i]);
    assign ad = d[32] ? -d : d;
    always_ff @(posedge clk) begin
      if (en) begin
        mag1[i] <= ad[31:0];
        neg1[i] <= d[32];
      end
    end
  end

  // stage 2: largest magnitude
  always_comb begin
    m_next = mag1[0];
    if (mag1[1] > m_next) m_next = mag1[1];
    if (mag1[2] > m_next) m_next = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2 <= mag1;
      neg2 <= neg1;
      m2   <= m_next;
    end
  end

  // stage 3: normalizing shift count
  assign len_next = bit_len32(m2);
  assign s_wide   = $signed({1'b0, len_next}) - 7'(NORM_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= mag2;
      neg3 <= neg2;
      s3   <= s_wide[SH_W-1:0];
      at3  <= (m2 == '0);
    end
  end

  // stage 4: scale each component to NORM_BITS
  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic [31:0] sh;
    logic [N_W:0] nz;
    assign sh = s3[SH_W-1] ? (mag3[i] << SH_W'(-s3)) : (mag3[i] >> s3);
    assign nz = {1'b0, sh[N_W-1:0]};
    always_ff @(posedge clk) begin
      if (en) begin
        n4[i]  <= sh[N_W-1:0];
        sn4[i] <= neg3[i] ? -$signed(nz) : $signed(nz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4  <= s3;
      at4 <= at3;
    end
  end

  // stage 5: squares and direction products
  for (genvar i = 0; i < 3; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        sq5[i] <= n4[i] * n4[i];
        pr5[i] <= dir[i] * sn4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5  <= s4;
      at5 <= at4;
    end
  end

  // stage 6: sums
  always_ff @(posedge clk) begin
    if (en) begin
      r26  <= R2_W'(sq5[0]) + R2_W'(sq5[1]) + R2_W'(sq5[2]);
      dot6 <= 39'(pr5[0]) + 39'(pr5[1]) + 39'(pr5[2]);
      s6   <= s5;
      at6  <= at5;
    end
  end

  // stage 7: sign and magnitude of the dot product
  assign adot = dot6[38] ? -dot6 : dot6;

  always_comb begin
    tag_next        = '0;
    tag_next.at_src = at6;
    tag_next.neg    = dot6[38];
    tag_next.s      = s6;
    tag_next.r2     = r26;
    tag_next.dm     = adot[DM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag_next;
    end
  end

  assign out_valid = v[7];

endmodule

// ----- sv/dpe_sqrt.sv -----
// ----------------------------------------------------------------------------
// dpe_sqrt: pipelined integer square root
// One result bit per stage on the squared radius held in the tag; the floor
// root lands in the tag's rt field.
// ----------------------------------------------------------------------------
module dpe_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  dpe_pkg::dpe_tag_t in_tag,
  output logic              out_valid,
  output dpe_pkg::dpe_tag_t out_tag
);
  import dpe_pkg::*;

  logic              v    [SQRT_STEPS+1];
  logic [RT_W+1:0]   rem  [SQRT_STEPS+1];
  logic [RT_W-1:0]   root [SQRT_STEPS+1];
  dpe_tag_t          tag  [SQRT_STEPS+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = in_tag;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] cand;
    logic [RT_W+3:0] diff;
    logic            ge;

    // bring down the next two bits and try the next root bit
    assign trial = {rem[k], tag[k].r2[R2_W-1-2*k -: 2]};
    assign cand  = {1'b0, root[k], 2'b01};
    assign diff  = trial - cand;
    assign ge    = (trial >= cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[RT_W+1:0] : trial[RT_W+1:0];
        root[k+1] <= {root[k][RT_W-2:0], ge};
        tag[k+1]  <= tag[k];
      end
    end
  end

  always_comb begin
    out_tag    = tag[SQRT_STEPS];
    out_tag.rt = root[SQRT_STEPS];
  end

  assign out_valid = v[SQRT_STEPS];

endmodule

// ----- sv/dpe_div.sv -----
// ----------------------------------------------------------------------------
// dpe_div: pipelined restoring divider
// 64-bit dividend by a divisor of up to R2_W bits, one quotient bit per
// stage; the tag travels alongside.
// ----------------------------------------------------------------------------
module dpe_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [dpe_pkg::DIV_W-1:0] dividend,
  input  logic [dpe_pkg::R2_W-1:0]  divisor,
  input  dpe_pkg::dpe_tag_t        in_tag,
  output logic                     out_valid,
  output logic [dpe_pkg::DIV_W-1:0] quotient,
  output dpe_pkg::dpe_tag_t        out_tag
);
  import dpe_pkg::*;

  logic             v   [DIV_STEPS+1];
  logic [R2_W-1:0]  rem [DIV_STEPS+1];
  logic [DIV_W-1:0] dvd [DIV_STEPS+1];
  logic [R2_W-1:0]  dvs [DIV_STEPS+1];
  dpe_tag_t         tag [DIV_STEPS+1];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign dvd[0] = dividend;
  assign dvs[0] = divisor;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [R2_W:0] trial;
    logic [R2_W:0] diff;
    logic          ge;

    // shift in the next dividend bit and subtract where it fits
    assign trial = {rem[k], dvd[k][DIV_W-1]};
    assign diff  = trial - {1'b0, dvs[k]};
    assign ge    = (trial >= {1'b0, dvs[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[R2_W-1:0] : trial[R2_W-1:0];
        dvd[k+1] <= {dvd[k][DIV_W-2:0], ge};
        dvs[k+1] <= dvs[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = v[DIV_STEPS];
  assign quotient  = dvd[DIV_STEPS];
  assign out_tag   = tag[DIV_STEPS];

endmodule

// ----- sv/dpe_scale.sv -----
// ----------------------------------------------------------------------------
// dpe_scale: mantissa chain before the conductivity divide
// Normalizes the ratio, multiplies by intensity and by the 1e6/(4 pi)
// constant, and keeps the binary exponent in the tag. Six stages.
// ----------------------------------------------------------------------------
module dpe_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [dpe_pkg::DIV_W-1:0] b,
  input  dpe_pkg::dpe_tag_t         in_tag,
  input  logic [31:0]               qn,
  input  logic [5:0]                lq,
  input  logic                      qzero,
  output logic                      out_valid,
  output logic [dpe_pkg::DIV_W-1:0] dividend,
  output dpe_pkg::dpe_tag_t         out_tag
);
  import dpe_pkg::*;

  logic [6:1] v;

  logic [DIV_W-1:0] b1;
  logic [6:0]       lb1;
  dpe_tag_t         t1, t2, t3, t4, t5;
  logic [31:0]      p2;
  logic [63:0]      prod3;
  logic [31:0]      p4;
  logic [63:0]      prod5;
  logic [62:0]      p6;

  logic [DIV_W-1:0] bsh;
  logic signed [EXP_W-1:0] ex2;
  dpe_tag_t         t1_next, t2_next, t4_next, out_tag_next;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  // stage 1: bit length of the ratio, zero test
  always_comb begin
    t1_next      = in_tag;
    t1_next.zero = (b == '0) || qzero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1  <= b;
      lb1 <= bit_len64(b);
      t1  <= t1_next;
    end
  end

  // stage 2: normalize to 32 significant bits
  assign bsh = (lb1 > 7'd32) ? (b1 >> (lb1 - 7'd32)) : (b1 << (7'd32 - lb1));
  assign ex2 = EXP_W'($signed({1'b0, lb1})) + EXP_W'($signed({1'b0, lq}))
             - EXP_W'(64);

  always_comb begin
    t2_next    = t1;
    t2_next.ex = ex2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= bsh[31:0];
      t2 <= t2_next;
    end
  end

  // stage 3: times normalized intensity
  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= qn * p2;
      t3    <= t2;
    end
  end

  // stage 4: back to 32 bits
  always_comb begin
    t4_next    = t3;
    t4_next.ex = t3.ex + (prod3[63] ? EXP_W'(32) : EXP_W'(31));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4 <= prod3[63] ? prod3[63:32] : prod3[62:31];
      t4 <= t4_next;
    end
  end

  // stage 5: times the physical constant
  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= p4 * CONST_MANT;
      t5    <= t4;
    end
  end

  // stage 6: back to 63 bits
  always_comb begin
    out_tag_next    = t5;
    out_tag_next.ex = t5.ex + EXP_W'(prod5[63]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6      <= prod5[63] ? prod5[63:1] : prod5[62:0];
      out_tag <= out_tag_next;
    end
  end

  assign dividend  = {1'b0, p6};
  assign out_valid = v[6];

endmodule

// ----- sv/dipole_potential_eval.sv -----
// ----------------------------------------------------------------------------
// dipole_potential_eval: potential of a current dipole at one point
// Throughput: one point per cycle while the output buffer has room; the
// front end, square root, three dividers and the scaling chain each add
// stages, and all of them stall together while the buffer is full and not read.
// A two-entry output buffer keeps points flowing while a result waits.
// Reset (synchronous, rst high) clears all valid bits and loads the register
// defaults: zero position, direction and intensity, conductivity 1.0.
// ----------------------------------------------------------------------------
module dipole_potential_eval (
  input  logic        clk,
  input  logic        rst,
  dpe_point_if.sink   point,
  dpe_result_if.source result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dpe_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] potential;
    logic                    at_source;
    logic                    saturated;
  } res_t;

  // configuration registers
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [31:0]        intensity;
  logic [23:0]        conductivity;
  logic [5:0]         lq;
  logic [31:0]        qn;
  logic [23:0]        sg;

  logic en;

  logic             fr_v;
  dpe_tag_t         fr_tag;
  logic             sq_v;
  dpe_tag_t         sq_tag;
  logic             d1_v;
  logic [DIV_W-1:0] d1_q;
  dpe_tag_t         d1_tag;
  logic             d2_v;
  logic [DIV_W-1:0] d2_q;
  dpe_tag_t         d2_tag;
  logic             sc_v;
  logic [DIV_W-1:0] sc_dvd;
  dpe_tag_t         sc_tag;
  logic             d3_v;
  logic [DIV_W-1:0] d3_q;
  dpe_tag_t         d3_tag;

  logic [3:1]              vt;
  logic signed [EXP_W-1:0] x1;
  logic [62:0]             q1;
  dpe_tag_t                t1, t2;
  logic [110:0]            sv2;
  logic                    big2;
  res_t                    fin;

  logic signed [EXP_W-1:0] nx;
  logic [110:0]            sv_next;
  logic                    big_next;
  logic [OUT_W-1:0]        lim;
  logic                    sat;
  logic [OUT_W-1:0]        mag;
  res_t                    fin_next;

  res_t       buf0, buf1;
  logic [1:0] cnt;
  logic       push, pop;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      dir_x        <= '0;
      dir_y        <= '0;
      dir_z        <= '0;
      intensity    <= '0;
      conductivity <= 24'd65536;
    end else if (cfg_we) begin
      unique case (dpe_reg_t'(cfg_index))
        REG_POS_X: pos_x        <= cfg_data;
        REG_POS_Y: pos_y        <= cfg_data;
        REG_POS_Z: pos_z        <= cfg_data;
        REG_DIR_X: dir_x        <= cfg_data[15:0];
        REG_DIR_Y: dir_y        <= cfg_data[15:0];
        REG_DIR_Z: dir_z        <= cfg_data[15:0];
        REG_INTEN: intensity    <= cfg_data;
        REG_COND:  conductivity <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // derive normalized intensity and effective conductivity
  always_ff @(posedge clk) begin
    lq <= bit_len32(intensity);
    qn <= intensity << (6'd32 - lq);
    sg <= (conductivity == '0) ? 24'd1 : conductivity;
  end

  // hold the whole pipeline only when the output buffer cannot take more
  assign en          = !(vt[3] && (cnt == 2'd2) && !result.ready);
  assign point.ready = en;

  dpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (point.valid),
    .px       (point.point_x),
    .py       (point.point_y),
    .pz       (point.point_z),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .out_valid(fr_v),
    .out_tag  (fr_tag)
  );

  dpe_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fr_v),
    .in_tag   (fr_tag),
    .out_valid(sq_v),
    .out_tag  (sq_tag)
  );

  // A = |D| * 2^26 / R2
  dpe_div u_div_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_v),
    .dividend ({sq_tag.dm, 26'd0}),
    .divisor  (sq_tag.r2),
    .in_tag   (sq_tag),
    .out_valid(d1_v),
    .quotient (d1_q),
    .out_tag  (d1_tag)
  );

  // B = A * 2^40 / R
  dpe_div u_div_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_v),
    .dividend ({d1_q[23:0], 40'd0}),
    .divisor  ({(R2_W-RT_W)'(0), d1_tag.rt}),
    .in_tag   (d1_tag),
    .out_valid(d2_v),
    .quotient (d2_q),
    .out_tag  (d2_tag)
  );

  dpe_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d2_v),
    .b        (d2_q),
    .in_tag   (d2_tag),
    .qn       (qn),
    .lq       (lq),
    .qzero    (intensity == '0),
    .out_valid(sc_v),
    .dividend (sc_dvd),
    .out_tag  (sc_tag)
  );

  // divide by conductivity
  dpe_div u_div_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sc_v),
    .dividend (sc_dvd),
    .divisor  ({(R2_W-24)'(0), sg}),
    .in_tag   (sc_tag),
    .out_valid(d3_v),
    .quotient (d3_q),
    .out_tag  (d3_tag)
  );

  // advance valid bits of the output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= '0;
    end else if (en) begin
      vt <= {vt[2:1], d3_v};
    end
  end

  // stage 1: final exponent
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= d3_tag.ex - (EXP_W'(d3_tag.s) <<< 1) + EXP_W'(X_BIAS);
      q1 <= d3_q[62:0];
      t1 <= d3_tag;
    end
  end

  // stage 2: apply the exponent
  assign nx = -x1;

  always_comb begin
    big_next = 1'b0;
    sv_next  = '0;
    if (!x1[EXP_W-1]) begin
      if (x1 >= EXP_W'(48)) big_next = 1'b1;
      else sv_next = {48'd0, q1} << x1[5:0];
    end else if (nx < EXP_W'(64)) begin
      sv_next = {48'd0, q1 >> nx[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv2  <= sv_next;
      big2 <= big_next;
      t2   <= t1;
    end
  end

  // stage 3: clip, sign and special cases
  assign lim = t2.neg ? NEG_LIMIT : POS_LIMIT;
  assign sat = big2 || (sv2 > {63'd0, lim});
  assign mag = sat ? lim : sv2[OUT_W-1:0];

  always_comb begin
    fin_next = '0;
    if (t2.at_src) begin
      fin_next.at_source = 1'b1;
    end else if (!t2.zero) begin
      fin_next.saturated = sat;
      fin_next.potential = t2.neg ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_next;
    end
  end

  // two-entry output buffer
  assign push = en && vt[3];
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) buf0 <= fin;
        else buf1 <= fin;
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          buf0 <= fin;
        end else begin
          buf0 <= buf1;
          buf1 <= fin;
        end
      end
      default: ;
    endcase
  end

  assign result.valid     = (cnt != 2'd0);
  assign result.potential = buf0.potential;
  assign result.at_source = buf0.at_source;
  assign result.saturated = buf0.saturated;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the dipole potential evaluator
// Streams measurement points through the point channel under several dipole
// settings and checks every result against a bit-accurate predictor of the
// fixed-point potential, its at-source flag and its saturation flag.
// ----------------------------------------------------------------------------
module tb_top;
  import dpe_pkg::*;

  typedef struct {
    logic [47:0] potential;
    logic        at_source;
    logic        saturated;
  } potential_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  dpe_point_if  pt ();
  dpe_result_if rs ();

  dipole_potential_eval dut (
    .clk       (clk),
    .rst       (rst),
    .point     (pt),
    .result    (rs),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // dipole settings as the block holds them
  logic signed [31:0] dip_pos [3];
  logic signed [15:0] dip_dir [3];
  logic [31:0]        dip_inten;
  logic [23:0]        dip_cond;

  potential_t expected_q [$];

  int  errors;
  int  n_points;
  int  n_checked;
  int  n_at_src;
  int  n_sat;
  int  n_neg;
  int  n_settings;
  bit  tx_idle;
  int  burst_left;
  int  rx_mode;
  int  rx_hold;
  int  rx_phase;
  longint cycles;

  localparam longint CYCLE_LIMIT = 400000;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int bit_length(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      v = v >> 1;
      n++;
    end
    return n;
  endfunction

  // keep tgt significant bits, track the exponent
  function automatic longint unsigned norm_to(longint unsigned v, int tgt, inout int e);
    int len;
    len = bit_length(v);
    if (len > tgt) begin
      v = v >> (len - tgt);
      e += len - tgt;
    end else if (len < tgt && v != 0) begin
      v = v << (tgt - len);
      e -= tgt - len;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic potential_t predict_potential(logic signed [31:0] px,
                                                   logic signed [31:0] py,
                                                   logic signed [31:0] pz);
    potential_t r;
    logic signed [31:0] pv [3];
    longint d;
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned m, n, r2, dm, rt, a, b, p, res, lim, sg;
    longint dot, sn;
    bit negres, sat;
    int s, ex, x;
    pv[0] = px; pv[1] = py; pv[2] = pz;
    m = 0; r2 = 0; dot = 0; res = 0; sat = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(pv[i]) - longint'(dip_pos[i]);
      neg[i] = d < 0;
      mag[i] = neg[i] ? longint'(-d) : d;
      if (mag[i] > m) m = mag[i];
    end
    r.potential = '0;
    r.saturated = 1'b0;
    r.at_source = (m == 0);
    if (m == 0) return r;
    s = bit_length(m) - NORM_BITS;
    for (int i = 0; i < 3; i++) begin
      n = (s >= 0) ? (mag[i] >> s) : (mag[i] << (-s));
      sn = neg[i] ? -longint'(n) : longint'(n);
      r2 += n * n;
      dot += longint'(dip_dir[i]) * sn;
    end
    negres = dot < 0;
    dm = negres ? longint'(-dot) : dot;
    rt = floor_sqrt(r2);
    a = (dm << 26) / r2;
    b = (a << 40) / rt;
    sg = (dip_cond == 0) ? 1 : dip_cond;
    lim = negres ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (b != 0 && dip_inten != 0) begin
      ex = 0;
      p = norm_to(b, 32, ex);
      p = norm_to(longint'(dip_inten) * p, 32, ex);
      p = norm_to(p * longint'(CONST_MANT), 63, ex);
      p = p / sg;
      x = ex + 2 * COORD_FRAC_BITS - 22 - 2 * s - 66 - CONST_EXP;
      if (x >= 0) begin
        if (x >= 48 || p > (lim >> x)) begin
          res = lim;
          sat = 1;
        end else begin
          res = p << x;
        end
      end else begin
        res = (-x >= 64) ? 0 : (p >> (-x));
        if (res > lim) begin
          res = lim;
          sat = 1;
        end
      end
    end
    r.potential = negres ? 48'(64'd0 - res) : 48'(res);
    r.saturated = sat;
    return r;
  endfunction

  // write one register while the block is idle
  task automatic write_reg(dpe_reg_t idx, logic [31:0] v);
    while (expected_q.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    case (idx)
      REG_POS_X: dip_pos[0] = v;
      REG_POS_Y: dip_pos[1] = v;
      REG_POS_Z: dip_pos[2] = v;
      REG_DIR_X: dip_dir[0] = v[15:0];
      REG_DIR_Y: dip_dir[1] = v[15:0];
      REG_DIR_Z: dip_dir[2] = v[15:0];
      REG_INTEN: dip_inten = v;
      REG_COND:  dip_cond = v[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_dipole(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                            logic [31:0] q, logic [31:0] sigma);
    write_reg(REG_POS_X, x);
    write_reg(REG_POS_Y, y);
    write_reg(REG_POS_Z, z);
    write_reg(REG_DIR_X, ex);
    write_reg(REG_DIR_Y, ey);
    write_reg(REG_DIR_Z, ez);
    write_reg(REG_INTEN, q);
    write_reg(REG_COND, sigma);
    n_settings++;
  endtask

  // value with a random bit length, so every magnitude range shows up
  function automatic logic [31:0] rand_len(int maxlen);
    int k;
    k = $urandom_range(0, maxlen);
    return (k >= 32) ? $urandom : ($urandom & ((32'd1 << k) - 1));
  endfunction

  task automatic random_dipole();
    logic [31:0] pos [3];
    for (int i = 0; i < 3; i++)
      pos[i] = ($urandom_range(0, 2) == 0) ? $urandom : rand_len(24) - rand_len(24);
    set_dipole(pos[0], pos[1], pos[2], $urandom, $urandom, $urandom,
               rand_len(32), ($urandom_range(0, 9) == 0) ? 32'd0 : rand_len(32));
  endtask

  // offer one point, hold it until accepted, record its expected result
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (tx_idle) begin
      if (burst_left == 0) begin
        pt.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    pt.valid = 1'b1;
    pt.point_x = x;
    pt.point_y = y;
    pt.point_z = z;
    do @(posedge clk); while (!pt.ready);
    expected_q.insert(expected_q.size(), predict_potential(x, y, z));
    n_points++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    pt.valid = 1'b0;
  endtask

  // point near the dipole with a random offset size, or anywhere at all
  task automatic send_random_point();
    logic [31:0] c [3];
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) c[i] = $urandom;
      else if (kind == 6) c[i] = dip_pos[i];
      else c[i] = dip_pos[i] + (($urandom_range(0, 1) != 0) ?
                                 rand_len(32) : -rand_len(32));
    end
    send_point(c[0], c[1], c[2]);
  endtask

  // edge values of points and settings
  task automatic test_directed();
    tx_idle = 0;
    rx_mode = 0;
    // reset defaults: zero moment gives zero, origin is the source
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 0, 0);
    stop_sending();
    set_dipole(0, 0, 0, 32'h4000, 0, 0, 32'hFFFF_FFFF, 32'd1);
    send_point(32'h0001_0000, 0, 0);
    send_point(32'hFFFF_0000, 0, 0);
    send_point(1, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(0, 32'h0001_0000, 0);
    send_point(0, 0, 0);
    stop_sending();
    // widest offsets, extreme directions, largest conductivity
    set_dipole(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000, 32'h7FFF, 32'h8000, 32'hFFFF_FFFF, 32'hFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(0, 0, 0);
    send_point(32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF);
    stop_sending();
    // zero intensity and zero conductivity taken as one
    set_dipole(32'h0010_0000, 0, 32'hFFF0_0000, 32'h7FFF, 32'h7FFF, 32'h7FFF,
               0, 0);
    send_point(0, 0, 0);
    stop_sending();
    write_reg(REG_INTEN, 32'h0000_1000);
    send_point(0, 0, 0);
    send_point(32'h0010_0000, 32'h0000_0100, 32'hFFF0_0000);
    send_point(32'h0010_0001, 32'h8000_0000, 32'hFFEF_FFFF);
    // direction orthogonal to the offset: zero dot product
    send_point(32'h0010_0000, 32'h0002_0000, 32'hFFF0_0000 - 32'h0002_0000);
    stop_sending();
  endtask

  // random settings and points, with idling on both sides except in every third phase
  task automatic test_random_settings(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      random_dipole();
      tx_idle = (ph % 3) != 0;
      rx_mode = ph % 3;
      repeat (per_phase) send_random_point();
      stop_sending();
    end
  endtask

  // long receiver hold-off while points keep coming
  task automatic test_backpressure();
    random_dipole();
    tx_idle = 0;
    rx_mode = 0;
    rx_hold = 700;
    repeat (300) send_random_point();
    stop_sending();
  endtask

  // sender pauses until the pipe is empty, then resumes
  task automatic test_drain_pause();
    tx_idle = 1;
    rx_mode = 1;
    repeat (40) send_random_point();
    stop_sending();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) send_random_point();
    stop_sending();
  endtask

  // receiver: ready pattern and hold-off counted here
  initial begin
    rs.ready = 1'b0;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (rx_hold > 0) begin
        rx_hold--;
        rs.ready = 1'b0;
      end else begin
        case (rx_mode)
          0: rs.ready = 1'b1;
          1: rs.ready = $urandom_range(0, 3) != 0;
          default: rs.ready = (rx_phase % 9) < 5;
        endcase
      end
    end
  end

  // result checker
  initial begin
    potential_t exp_r;
    forever begin
      @(posedge clk);
      if (!rst && rs.valid && rs.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no point pending: potential %h", rs.potential);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          n_checked++;
          if (exp_r.at_source) n_at_src++;
          if (exp_r.saturated) n_sat++;
          if (exp_r.potential[47]) n_neg++;
          if (rs.potential !== exp_r.potential) begin
            $error("potential: expected %h, got %h", exp_r.potential, rs.potential);
            errors++;
          end
          if (rs.at_source !== exp_r.at_source) begin
            $error("at_source: expected %b, got %b", exp_r.at_source, rs.at_source);
            errors++;
          end
          if (rs.saturated !== exp_r.saturated) begin
            $error("saturated: expected %b, got %b", exp_r.saturated, rs.saturated);
            errors++;
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    errors = 0; n_points = 0; n_checked = 0; n_at_src = 0; n_sat = 0;
    n_neg = 0; n_settings = 0; tx_idle = 0; burst_left = 0;
    rx_mode = 0; rx_hold = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    pt.valid = 1'b0; pt.point_x = '0; pt.point_y = '0; pt.point_z = '0;
    for (int i = 0; i < 3; i++) begin
      dip_pos[i] = '0;
      dip_dir[i] = '0;
    end
    dip_inten = '0;
    dip_cond = 24'd65536;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_settings(8, 40);
    test_backpressure();
    test_drain_pause();
    test_random_settings(2, 30);

    while (expected_q.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Covered %0d points under %0d dipole settings, %0d results checked",
             n_points, n_settings, n_checked);
    $display("  %0d at the source, %0d saturated, %0d negative", n_at_src, n_sat, n_neg);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
